[sv/rgbhsv_pkg.sv]
// shared types and constants for the rgb to hsv pixel unit
package rgbhsv_pkg;

	localparam int unsigned CHAN_W = 8;
	localparam int unsigned PIXEL_W = 3 * CHAN_W;
	localparam int unsigned DIFF_W = CHAN_W + 1;
	localparam int unsigned NUM_W = 16;
	localparam int unsigned HUE_SUM_W = 18;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
	localparam int unsigned PROD_W = NUM_W + RECIP_W;
	localparam int unsigned RECIP_DEPTH = 1 << CHAN_W;

	localparam int unsigned HUE_SCALE = 30;
	localparam int unsigned HUE_OFF_GREEN = 60;
	localparam int unsigned HUE_OFF_BLUE = 120;
	localparam int unsigned HUE_WRAP = 180;
	localparam int unsigned SAT_SCALE = 255;

	typedef enum logic [1:0] {
		MAX_RED,
		MAX_GREEN,
		MAX_BLUE
	} max_sel_t;

endpackage

[sv/rgb_to_hsv_pixel_unit.sv]
// rgb to hsv pixel unit: three-stage pipeline with reciprocal-table dividers
// pipeline: three register stages, s1, s2 and s3; s3 is the output register
// throughput: one pixel per cycle while the output is not stalled; both divides are a
// 256-entry reciprocal table lookup followed by one 16x25 multiply, so nothing iterates
// stalls collapse bubbles stage by stage and the output register holds under backpressure
// reset: arst_n clears the stage valid bits at once; data registers are not reset
module rgb_to_hsv_pixel_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rgbhsv_pkg::PIXEL_W-1:0] s_axis_tdata,  // blue, green, red
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rgbhsv_pkg::PIXEL_W-1:0] m_axis_tdata   // hue, saturation, brightness
);

	localparam int unsigned CW = rgbhsv_pkg::CHAN_W;

	// reciprocal table: ceil(2^24 / d), exact floor quotient for 16-bit numerators
	logic [rgbhsv_pkg::RECIP_W-1:0] recip_tab [rgbhsv_pkg::RECIP_DEPTH];

	for (genvar gi = 0; gi < rgbhsv_pkg::RECIP_DEPTH; gi++) begin : g_recip
		localparam longint unsigned Den = (gi == 0) ? 1 : gi;
		localparam longint unsigned Rv =
			((64'd1 << rgbhsv_pkg::RECIP_SHIFT) + Den - 1) / Den;
		assign recip_tab[gi] = rgbhsv_pkg::RECIP_W'(Rv);
	end

	// stage ready chain
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || m_axis_tready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	// stage 1: max, min, delta, which channel leads
	logic [CW-1:0] blue, green, red;
	logic [CW-1:0] mx, mn;
	logic red_max, green_max;
	rgbhsv_pkg::max_sel_t sel;
	logic signed [rgbhsv_pkg::DIFF_W-1:0] diff;

	assign blue  = s_axis_tdata[CW-1:0];
	assign green = s_axis_tdata[2*CW-1:CW];
	assign red   = s_axis_tdata[3*CW-1:2*CW];

	always_comb begin
		red_max = (red >= green) && (red >= blue);
		green_max = !red_max && (green >= blue);
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		priority if (red_max) begin
			mx = red;
			sel = rgbhsv_pkg::MAX_RED;
			diff = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green_max) begin
			mx = green;
			sel = rgbhsv_pkg::MAX_GREEN;
			diff = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			mx = blue;
			sel = rgbhsv_pkg::MAX_BLUE;
			diff = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	logic [CW-1:0] mx_s1, delta_s1;
	rgbhsv_pkg::max_sel_t sel_s1;
	logic signed [rgbhsv_pkg::DIFF_W-1:0] diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			mx_s1 <= mx;
			delta_s1 <= mx - mn;
			sel_s1 <= sel;
			diff_s1 <= diff;
		end
	end

	// stage 2: numerators and reciprocal lookups
	logic [rgbhsv_pkg::HUE_SUM_W-1:0] hue_off;
	logic signed [rgbhsv_pkg::HUE_SUM_W-1:0] hue_sum;
	logic [rgbhsv_pkg::NUM_W-1:0] sat_num;

	always_comb begin
		unique case (sel_s1)
			rgbhsv_pkg::MAX_RED:
				// negative hue wraps by a full turn in two-degree units
				hue_off = diff_s1[rgbhsv_pkg::DIFF_W-1]
					? rgbhsv_pkg::HUE_SUM_W'(rgbhsv_pkg::HUE_WRAP) : '0;
			rgbhsv_pkg::MAX_GREEN:
				hue_off = rgbhsv_pkg::HUE_SUM_W'(rgbhsv_pkg::HUE_OFF_GREEN);
			rgbhsv_pkg::MAX_BLUE:
				hue_off = rgbhsv_pkg::HUE_SUM_W'(rgbhsv_pkg::HUE_OFF_BLUE);
			default:
				hue_off = '0;
		endcase
		hue_sum = rgbhsv_pkg::HUE_SUM_W'(diff_s1)
			* $signed(rgbhsv_pkg::HUE_SUM_W'(rgbhsv_pkg::HUE_SCALE))
			+ $signed(hue_off * rgbhsv_pkg::HUE_SUM_W'(delta_s1));
		sat_num = rgbhsv_pkg::NUM_W'(delta_s1) * rgbhsv_pkg::NUM_W'(rgbhsv_pkg::SAT_SCALE);
	end

	logic [CW-1:0] mx_s2;
	logic [rgbhsv_pkg::NUM_W-1:0] hue_num_s2, sat_num_s2;
	logic [rgbhsv_pkg::RECIP_W-1:0] recip_mx_s2, recip_delta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			mx_s2 <= mx_s1;
			hue_num_s2 <= hue_sum[rgbhsv_pkg::NUM_W-1:0];
			sat_num_s2 <= sat_num;
			recip_mx_s2 <= recip_tab[mx_s1];
			recip_delta_s2 <= recip_tab[delta_s1];
		end
	end

	// stage 3: reciprocal multiplies; a zero numerator covers black and gray pixels
	logic [rgbhsv_pkg::PROD_W-1:0] hue_prod, sat_prod;

	assign hue_prod = rgbhsv_pkg::PROD_W'(hue_num_s2) * rgbhsv_pkg::PROD_W'(recip_delta_s2);
	assign sat_prod = rgbhsv_pkg::PROD_W'(sat_num_s2) * rgbhsv_pkg::PROD_W'(recip_mx_s2);

	logic [CW-1:0] hue_s3, sat_s3, mx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			hue_s3 <= hue_prod[rgbhsv_pkg::RECIP_SHIFT +: CW];
			sat_s3 <= sat_prod[rgbhsv_pkg::RECIP_SHIFT +: CW];
			mx_s3 <= mx_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata = {mx_s3, sat_s3, hue_s3};

`ifndef ASSERT_OFF
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (hue_s3 < CW'(rgbhsv_pkg::HUE_WRAP)))
		else $error("hue out of range");

	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && (mx_s3 == '0)) |-> ((hue_s3 == '0) && (sat_s3 == '0)))
		else $error("black pixel with nonzero hue or saturation");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(mx_s1) && $stable(delta_s1)
			&& $stable(diff_s1)))
		else $error("stage 1 lost data under stall");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ready_s3) |=> (valid_s2 && $stable(hue_num_s2)
			&& $stable(sat_num_s2)))
		else $error("stage 2 lost data under stall");
`endif

endmodule

[bench/tb_rgb_to_hsv_pixel_unit.sv]
// self-checking testbench for the rgb to hsv pixel unit, directed and random pixels against a predictor
module tb_rgb_to_hsv_pixel_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_PIXELS = 1630;
	localparam int unsigned HOLD_AT = 300;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned QUIET_FROM = 900;
	localparam int unsigned QUIET_TO = 1200;
	localparam int unsigned TAIL_CYCLES = 10;
	localparam int unsigned MAX_REPORTS = 30;

	typedef struct {
		logic [rgbhsv_pkg::CHAN_W-1:0] blue;
		logic [rgbhsv_pkg::CHAN_W-1:0] green;
		logic [rgbhsv_pkg::CHAN_W-1:0] red;
		bit                drain;
	} pixel_req_t;

	typedef struct {
		logic [rgbhsv_pkg::CHAN_W-1:0] hue;
		logic [rgbhsv_pkg::CHAN_W-1:0] saturation;
		logic [rgbhsv_pkg::CHAN_W-1:0] brightness;
	} hsv_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [rgbhsv_pkg::PIXEL_W-1:0] s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [rgbhsv_pkg::PIXEL_W-1:0] m_axis_tdata;

	pixel_req_t pixel_queue[$];
	hsv_t       pending_hsv[$];
	bit         in_fire = 1'b0;
	int         n_total = 0;
	int         n_sent = 0;
	int         n_got = 0;
	int         n_errors = 0;
	int         n_in_stalls = 0;
	int         max_count[3] = '{0, 0, 0};
	int         n_gray = 0;
	int unsigned hold_left = 0;
	bit         hold_done = 1'b0;

	rgb_to_hsv_pixel_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// hsv of one pixel, exact integer division, hue in two-degree steps
	function automatic hsv_t convert_pixel(logic [rgbhsv_pkg::CHAN_W-1:0] b,
			logic [rgbhsv_pkg::CHAN_W-1:0] g, logic [rgbhsv_pkg::CHAN_W-1:0] r);
		int ib;
		int ig;
		int ir;
		int mx;
		int mn;
		int dlt;
		int num;
		rgbhsv_pkg::max_sel_t sel;
		hsv_t res;
		ib = int'(b);
		ig = int'(g);
		ir = int'(r);
		// red wins ties over green, green over blue
		mx = ir;
		sel = rgbhsv_pkg::MAX_RED;
		if (ig > mx) begin
			mx = ig;
			sel = rgbhsv_pkg::MAX_GREEN;
		end
		if (ib > mx) begin
			mx = ib;
			sel = rgbhsv_pkg::MAX_BLUE;
		end
		mn = ir;
		if (ig < mn) mn = ig;
		if (ib < mn) mn = ib;
		dlt = mx - mn;
		res.hue = '0;
		res.saturation = '0;
		res.brightness = mx[rgbhsv_pkg::CHAN_W-1:0];
		max_count[sel]++;
		if (dlt == 0) n_gray++;
		if (mx != 0 && dlt != 0) begin
			res.saturation = rgbhsv_pkg::CHAN_W'((int'(rgbhsv_pkg::SAT_SCALE) * dlt) / mx);
			case (sel)
				rgbhsv_pkg::MAX_RED: num = int'(rgbhsv_pkg::HUE_SCALE) * (ig - ib);
				rgbhsv_pkg::MAX_GREEN: num = int'(rgbhsv_pkg::HUE_SCALE) * (ib - ir)
					+ int'(rgbhsv_pkg::HUE_OFF_GREEN) * dlt;
				default: num = int'(rgbhsv_pkg::HUE_SCALE) * (ir - ig)
					+ int'(rgbhsv_pkg::HUE_OFF_BLUE) * dlt;
			endcase
			if (num < 0) num += int'(rgbhsv_pkg::HUE_WRAP) * dlt;
			res.hue = rgbhsv_pkg::CHAN_W'(num / dlt);
		end
		return res;
	endfunction

	function automatic logic [rgbhsv_pkg::CHAN_W-1:0] corner_val();
		case ($urandom_range(4))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			3: return 8'd255;
			default: return rgbhsv_pkg::CHAN_W'($urandom);
		endcase
	endfunction

	function automatic bit take_break();
		return !(n_sent >= QUIET_FROM && n_sent < QUIET_TO) && $urandom_range(99) < 15;
	endfunction

	task automatic add_pixel(int b, int g, int r, bit drain = 1'b0);
		pixel_req_t px;
		px.blue = rgbhsv_pkg::CHAN_W'(b);
		px.green = rgbhsv_pkg::CHAN_W'(g);
		px.red = rgbhsv_pkg::CHAN_W'(r);
		px.drain = drain;
		pixel_queue.push_back(px);
	endtask

	task automatic add_random_pixel(bit drain);
		int pick;
		int v;
		int lo;
		pick = $urandom_range(99);
		if (pick < 40) begin
			add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255), drain);
		end else if (pick < 55) begin
			v = $urandom_range(255);
			add_pixel(v, v, v, drain);
		end else if (pick < 70) begin
			// two channels share the maximum
			v = $urandom_range(255, 1);
			lo = $urandom_range(v);
			case ($urandom_range(2))
				0: add_pixel(lo, v, v, drain);
				1: add_pixel(v, lo, v, drain);
				default: add_pixel(v, v, lo, drain);
			endcase
		end else if (pick < 85) begin
			add_pixel($urandom_range(7), $urandom_range(7), $urandom_range(7), drain);
		end else begin
			add_pixel(corner_val(), corner_val(), corner_val(), drain);
		end
	endtask

	task automatic check_field(string name, logic [rgbhsv_pkg::CHAN_W-1:0] exp_v,
			logic [rgbhsv_pkg::CHAN_W-1:0] act_v);
		if (act_v !== exp_v) begin
			n_errors++;
			if (n_errors <= MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	// request driver: a new pixel goes out only once the previous one was taken
	always @(negedge clk) begin : drive_pixels
		pixel_req_t nxt;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (pixel_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (pixel_queue[0].drain && pending_hsv.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (take_break()) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				nxt = pixel_queue.pop_front();
				s_axis_tdata <= {nxt.red, nxt.green, nxt.blue};
				s_axis_tvalid <= 1'b1;
			end
		end
	end

	// result side ready, with one long hold-off to fill the pipeline
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && n_sent >= HOLD_AT) begin
				m_axis_tready <= 1'b0;
				hold_left <= HOLD_CYCLES - 1;
				hold_done <= 1'b1;
			end else begin
				m_axis_tready <= !take_break();
			end
		end
	end

	always @(posedge clk) begin : watch_ports
		hsv_t exp_hsv;
		if (arst_n) begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && !s_axis_tready) n_in_stalls++;
			if (m_axis_tvalid && m_axis_tready) begin
				n_got++;
				if (pending_hsv.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t ns: unexpected result, expected none, got 0x%06h",
							$time, m_axis_tdata);
				end else begin
					exp_hsv = pending_hsv.pop_front();
					check_field("hue", exp_hsv.hue, m_axis_tdata[rgbhsv_pkg::CHAN_W-1:0]);
					check_field("saturation", exp_hsv.saturation,
						m_axis_tdata[2*rgbhsv_pkg::CHAN_W-1:rgbhsv_pkg::CHAN_W]);
					check_field("brightness", exp_hsv.brightness,
						m_axis_tdata[3*rgbhsv_pkg::CHAN_W-1:2*rgbhsv_pkg::CHAN_W]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				n_sent++;
				pending_hsv.push_back(convert_pixel(s_axis_tdata[rgbhsv_pkg::CHAN_W-1:0],
					s_axis_tdata[2*rgbhsv_pkg::CHAN_W-1:rgbhsv_pkg::CHAN_W],
					s_axis_tdata[3*rgbhsv_pkg::CHAN_W-1:2*rgbhsv_pkg::CHAN_W]));
			end
		end
	end

	initial begin
		// directed corners: black, white, gray, primaries, ties, wrapped hue
		add_pixel(0, 0, 0);
		add_pixel(255, 255, 255);
		add_pixel(128, 128, 128);
		add_pixel(0, 0, 255);
		add_pixel(0, 255, 0);
		add_pixel(255, 0, 0);
		add_pixel(0, 255, 255);
		add_pixel(255, 255, 0);
		add_pixel(200, 0, 200);
		add_pixel(1, 0, 255);
		add_pixel(0, 1, 255);
		add_pixel(0, 0, 1);
		add_pixel(0, 1, 0);
		add_pixel(1, 0, 0);
		add_pixel(1, 1, 0);
		add_pixel(254, 255, 255);
		add_pixel(0, 254, 255);
		add_pixel(170, 85, 0);
		add_pixel(85, 170, 255);
		add_pixel(255, 170, 85);
		add_pixel(7, 3, 5);
		add_pixel(250, 255, 5);
		for (int i = 0; i < RANDOM_PIXELS; i++)
			add_random_pixel(i == 0 || i == 700);
		n_total = pixel_queue.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_sent < n_total) @(posedge clk);
		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d pixels checked, %0d gray, max channel red/green/blue %0d/%0d/%0d",
			n_got, n_gray, max_count[rgbhsv_pkg::MAX_RED], max_count[rgbhsv_pkg::MAX_GREEN],
			max_count[rgbhsv_pkg::MAX_BLUE]);
		$display("run: %0d cycles of input back-pressure, %0d field mismatches",
			n_in_stalls, n_errors);
		if (n_errors == 0)
			$display("** rgb_to_hsv_pixel_unit: PASSED **");
		else
			$display("** rgb_to_hsv_pixel_unit: FAILED **");
		$finish;
	end

	initial begin
		#400000;
		$display("timeout with %0d of %0d pixels sent, %0d results", n_sent, n_total, n_got);
		$display("** rgb_to_hsv_pixel_unit: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/rgbhsv_pkg.sv
sv/rgb_to_hsv_pixel_unit.sv
bench/tb_rgb_to_hsv_pixel_unit.sv
